/* hw/rtl/iibt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iibt_pkg
// shared types and codes for the instance id binding table
// ----------------------------------------------------------------------------
package iibt_pkg;

	localparam int ACTION_W = 3;
	localparam int INST_W   = 7;
	localparam int TASK_W   = 31;
	localparam int VALUE_W  = 31;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_REQUEST    = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_BIND       = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_TASK_BY_ID = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_ID_BY_TASK = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CLOSE      = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd5;

	// entry states
	localparam logic [1:0] ST_FREE   = 2'd0;
	localparam logic [1:0] ST_OPENED = 2'd1;
	localparam logic [1:0] ST_BOUND  = 2'd2;

	// issued id range
	localparam logic [INST_W-1:0] ID_FIRST = 7'd11;
	localparam logic [INST_W-1:0] ID_LAST  = 7'd100;

	// query token handed from cell to cell
	typedef struct packed {
		logic                vld;
		logic [ACTION_W-1:0] action;
		logic [INST_W-1:0]   inst;
		logic [TASK_W-1:0]   task_id;
		logic                hit;
		logic [VALUE_W-1:0]  value;
	} iibt_tok_t;

endpackage
`default_nettype wire

/* hw/rtl/iibt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iibt_cell
// one table entry; applies the passing token and hands it on through a register
// ----------------------------------------------------------------------------
module iibt_cell
	import iibt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire iibt_tok_t tok_in,
	output iibt_tok_t      tok_out
);

	logic [INST_W-1:0] inst_q, inst_d;
	logic [TASK_W-1:0] task_q, task_d;
	logic [1:0]        state_q, state_d;
	iibt_tok_t         tok_q, tok_d;
	logic              inst_eq;
	logic              task_eq;

	assign inst_eq = (inst_q == tok_in.inst);
	assign task_eq = (task_q == tok_in.task_id);

	always_comb begin
		tok_d   = tok_in;
		inst_d  = inst_q;
		task_d  = task_q;
		state_d = state_q;
		if (tok_in.vld) begin
			case (tok_in.action)
				ACT_REQUEST: begin
					if (!tok_in.hit && state_q == ST_FREE) begin
						inst_d    = tok_in.inst;
						task_d    = '0;
						state_d   = ST_OPENED;
						tok_d.hit = 1'b1;
					end
				end
				ACT_BIND: begin
					if (!tok_in.hit && tok_in.inst >= ID_FIRST &&
					    state_q == ST_OPENED && inst_eq) begin
						task_d    = tok_in.task_id;
						state_d   = ST_BOUND;
						tok_d.hit = 1'b1;
					end
				end
				ACT_TASK_BY_ID: begin
					if (!tok_in.hit && state_q == ST_BOUND && inst_eq) begin
						tok_d.value = task_q;
						tok_d.hit   = 1'b1;
					end
				end
				ACT_ID_BY_TASK: begin
					if (!tok_in.hit && state_q == ST_BOUND && task_eq) begin
						tok_d.value = {{(VALUE_W-INST_W){1'b0}}, inst_q};
						tok_d.hit   = 1'b1;
					end
				end
				ACT_CLOSE: begin
					if (!tok_in.hit && inst_eq) begin
						inst_d    = '0;
						task_d    = '0;
						state_d   = ST_FREE;
						tok_d.hit = 1'b1;
					end
				end
				ACT_CLEAR: begin
					inst_d    = '0;
					task_d    = '0;
					state_d   = ST_FREE;
					tok_d.hit = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inst_q  <= '0;
			task_q  <= '0;
			state_q <= ST_FREE;
			tok_q   <= '0;
		end else begin
			inst_q  <= inst_d;
			task_q  <= task_d;
			state_q <= state_d;
			tok_q   <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

/* hw/rtl/instance_id_binding_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// instance_id_binding_table
// table of issued instance ids bound to task ids, built as a row of cells
// ----------------------------------------------------------------------------
// Each beat on the slave side is one action (request id, bind, task by id,
// id by task, close, clear all) and gives exactly one beat on the master
// side. The action is captured into a token that walks the row of ENTRIES
// cells, one cell per clock; each cell holds one entry and the first
// matching cell acts on the token, but clear all frees every cell. The
// result leaves the row into a pending register and from there into the
// output register. One action is in flight at a time; a new beat is taken as
// soon as the previous result has reached the output register, even while
// that result still waits for m_tready. Reset leaves every entry free and
// the id counter at 11.
// ----------------------------------------------------------------------------
module instance_id_binding_table
	import iibt_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // instance_id [6:0], task_id [37:7]
	input  wire logic [2:0]  s_tuser,  // action [2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // value [30:0]
	output logic [0:0]       m_tuser   // status [0]
);

	// token chain: tok[0] is the captured beat, tok[ENTRIES] leaves the row
	iibt_tok_t           tok [0:ENTRIES];
	iibt_tok_t           in_tok_q;
	logic [ENTRIES:0]    chain_vld;

	logic                busy_q;
	logic [INST_W-1:0]   next_id_q;
	logic                pend_vld_q;
	logic                pend_status_q;
	logic [VALUE_W-1:0]  pend_value_q;
	logic                out_vld_q;
	logic                out_status_q;
	logic [VALUE_W-1:0]  out_value_q;

	logic                in_beat;
	logic                out_free;
	logic [ACTION_W-1:0] in_action;

	assign s_tready  = !busy_q;
	assign in_beat   = s_tvalid && s_tready;
	assign out_free  = !out_vld_q || m_tready;
	assign in_action = s_tuser;

	// capture of the incoming beat; a request carries the id to issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tok_q  <= '0;
			next_id_q <= ID_FIRST;
		end else begin
			in_tok_q.vld     <= in_beat;
			in_tok_q.action  <= in_action;
			in_tok_q.task_id <= s_tdata[37:7];
			in_tok_q.hit     <= 1'b0;
			if (in_action == ACT_REQUEST) begin
				in_tok_q.inst  <= next_id_q;
				in_tok_q.value <= {{(VALUE_W-INST_W){1'b0}}, next_id_q};
			end else begin
				in_tok_q.inst  <= s_tdata[6:0];
				in_tok_q.value <= '0;
			end
			if (in_beat) begin
				if (in_action == ACT_REQUEST) begin
					// counter runs 11..100 then wraps
					if (next_id_q < ID_LAST)
						next_id_q <= next_id_q + INST_W'(1);
					else
						next_id_q <= ID_FIRST;
				end else if (in_action == ACT_CLEAR) begin
					next_id_q <= ID_FIRST;
				end
			end
		end
	end

	assign tok[0] = in_tok_q;

	// row of entry cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		iibt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	for (genvar i = 0; i <= ENTRIES; i++) begin : g_vld
		assign chain_vld[i] = tok[i].vld;
	end

	// result pending stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (in_beat)
				busy_q <= 1'b1;
			if (tok[ENTRIES].vld)
				pend_vld_q <= 1'b1;
			if (pend_vld_q && out_free) begin
				out_vld_q  <= 1'b1;
				pend_vld_q <= 1'b0;
				busy_q     <= 1'b0;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok[ENTRIES].vld) begin
			pend_status_q <= !tok[ENTRIES].hit;
			pend_value_q  <= tok[ENTRIES].value;
		end
		if (pend_vld_q && out_free) begin
			out_status_q <= pend_status_q;
			out_value_q  <= pend_value_q;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = {1'b0, out_value_q};
	assign m_tuser[0] = out_status_q;

	// at most one token anywhere in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_vld))
		else $error("more than one token in the cell row");

	// a token never reaches the end while a result is still pending
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		tok[ENTRIES].vld |-> !pend_vld_q)
		else $error("pending result overwritten");

	// a pending result belongs to the action in flight
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> busy_q)
		else $error("pending result without an action in flight");

	// id counter stays in its range
	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		(next_id_q >= ID_FIRST) && (next_id_q <= ID_LAST))
		else $error("id counter out of range");

endmodule
`default_nettype wire
